>>> rtl/core/fla_pkg.sv
// fla_pkg: shared types and constants for the flow log aggregation table.
// Holds the transaction payload structs, the token handed along the cell chain,
// and the protocol and status codes. No dependencies.
package fla_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int IDX_W     = 6;
    localparam int USED_W    = 7;
    localparam int CNT_W     = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [7:0] IP_ICMP = 8'd1;
    localparam logic [7:0] IP_TCP  = 8'd6;
    localparam logic [7:0] IP_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_NEW     = 3'd1,
        ST_FULL    = 3'd2,
        ST_IGNORED = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [7:0]        protocol;
        logic [31:0]       source_address;
        logic [31:0]       dest_address;
        logic [15:0]       source_port;
        logic [15:0]       dest_port;
        logic [7:0]        verdict;
        logic signed [7:0] cause;
        logic [31:0]       event_seconds;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  row_index;
        logic [CNT_W-1:0]  row_count;
        logic [USED_W-1:0] rows_used;
    } t_out;

    // 120-bit match key
    typedef struct packed {
        logic [7:0]  protocol;
        logic [7:0]  verdict;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  cause;
    } t_key;

    // Transaction as it travels down the chain
    typedef struct packed {
        logic             vld;
        logic             clr;
        logic             known;   // protocol is ICMP, TCP or UDP
        logic             done;    // some row matched or was claimed
        logic             hit;     // done by a match (else by a claim)
        t_key             key;
        logic [31:0]      secs;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } t_tok;

endpackage

>>> rtl/core/flow_log_aggregation_table.sv
// flow_log_aggregation_table: top level, a chain of DEPTH row cells and an
// output register. Depends on fla_pkg and fla_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction
//   per item: a packet event (kind 0) or a clear of all rows (kind 1).
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one result per item, in input order: status, row index, hit count and
//   number of rows in use.
//   Each item walks the row cells one per cycle; cell i compares against its
//   row, bumps its saturating count on a match, or claims the row if it is the
//   first empty one. Known-protocol events that no cell takes report table full.
//   Items pass the DEPTH cell registers, then the output register; the chain
//   is fully pipelined, one item per cycle unless the receiver stalls. Items
//   already in flight see every earlier item's row updates in order.
//   Reset empties the table (row valid bits and rows-in-use count cleared) and
//   drops any transaction in flight. Row keys, counts and times are not reset.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   o_in_ready drops until the result is taken.
module flow_log_aggregation_table #(
    parameter int DEPTH = fla_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fla_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fla_pkg::t_out o_out_data
);

    fla_pkg::t_tok               w_tok [0:DEPTH];
    logic                        w_adv;
    logic                        w_icmp;

    logic                        r_out_valid;
    fla_pkg::t_out               r_out;
    logic [fla_pkg::USED_W-1:0]  r_used;

    fla_pkg::t_tok               w_last;
    fla_pkg::t_out               n_out;
    logic [fla_pkg::USED_W-1:0]  n_used;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    assign w_icmp = (i_in_data.protocol == fla_pkg::IP_ICMP);

    always_comb begin
        w_tok[0]              = '0;
        w_tok[0].vld          = i_in_valid;
        w_tok[0].clr          = i_in_data.kind;
        w_tok[0].known        = i_in_data.protocol inside
            {fla_pkg::IP_ICMP, fla_pkg::IP_TCP, fla_pkg::IP_UDP};
        w_tok[0].key.protocol = i_in_data.protocol;
        w_tok[0].key.verdict  = i_in_data.verdict;
        w_tok[0].key.src      = i_in_data.source_address;
        w_tok[0].key.dst      = i_in_data.dest_address;
        w_tok[0].key.sport    = w_icmp ? 16'd0 : i_in_data.source_port;
        w_tok[0].key.dport    = w_icmp ? 16'd0 : i_in_data.dest_port;
        w_tok[0].key.cause    = i_in_data.cause;
        w_tok[0].secs         = i_in_data.event_seconds;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fla_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_adv),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1])
        );
    end

    assign w_last = w_tok[DEPTH];

    always_comb begin
        n_used           = r_used;
        n_out.status     = fla_pkg::ST_FULL;
        n_out.row_index  = '0;
        n_out.row_count  = '0;
        if (w_last.clr) begin
            n_used       = '0;
            n_out.status = fla_pkg::ST_CLEARED;
        end else if (!w_last.known) begin
            n_out.status = fla_pkg::ST_IGNORED;
        end else if (w_last.done) begin
            n_out.row_index = w_last.idx;
            n_out.row_count = w_last.cnt;
            if (w_last.hit) begin
                n_out.status = fla_pkg::ST_MATCH;
            end else begin
                n_out.status = fla_pkg::ST_NEW;
                n_used       = r_used + fla_pkg::USED_W'(1);
            end
        end
        n_out.rows_used = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else if (w_adv) begin
            r_out_valid <= w_last.vld;
            if (w_last.vld) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last.vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == fla_pkg::ST_CLEARED
        |-> o_out_data.rows_used == '0 && o_out_data.row_count == '0)
        else $error("clear result reports rows in use");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == fla_pkg::ST_NEW
        |-> o_out_data.row_count == fla_pkg::CNT_W'(1))
        else $error("new row count is not one");

    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == fla_pkg::ST_MATCH
        |-> o_out_data.row_count > fla_pkg::CNT_W'(1))
        else $error("matched row count too small");

    // A stalled receiver freezes the chain: no new transaction enters.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");
`endif

endmodule

>>> rtl/core/fla_cell.sv
// fla_cell: one table row plus one stage of the transaction chain.
// Compares the passing transaction with its row, updates or claims the row.
// Depends on fla_pkg.
module fla_cell #(
    parameter int CELL_ID = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fla_pkg::t_tok i_tok,
    output fla_pkg::t_tok o_tok
);

    localparam int IW = fla_pkg::IDX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID % (2 ** IW));

    logic                       r_vld;
    fla_pkg::t_key              r_key;
    logic [fla_pkg::CNT_W-1:0]  r_cnt;
    logic [31:0]                r_time;
    fla_pkg::t_tok              r_tok;

    logic                       w_live;
    logic                       w_hit;
    logic                       w_claim;
    logic [fla_pkg::CNT_W-1:0]  w_inc;
    fla_pkg::t_tok              n_tok;

    // Rows fill from the front, so the first empty row reached without a
    // match means no later row can match either.
    assign w_live  = i_tok.vld && !i_tok.clr && i_tok.known && !i_tok.done;
    assign w_hit   = w_live && r_vld && (r_key == i_tok.key);
    assign w_claim = w_live && !r_vld;
    assign w_inc   = (r_cnt == fla_pkg::COUNT_MAX) ? r_cnt : r_cnt + fla_pkg::CNT_W'(1);

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.done = 1'b1;
            n_tok.hit  = 1'b1;
            n_tok.idx  = MY_IDX;
            n_tok.cnt  = w_inc;
        end else if (w_claim) begin
            n_tok.done = 1'b1;
            n_tok.hit  = 1'b0;
            n_tok.idx  = MY_IDX;
            n_tok.cnt  = fla_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en && i_tok.vld) begin
            if (i_tok.clr) begin
                r_vld <= 1'b0;
            end else if (w_claim) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_hit) begin
                r_cnt  <= w_inc;
                r_time <= i_tok.secs;
            end else if (w_claim) begin
                r_key  <= i_tok.key;
                r_cnt  <= fla_pkg::CNT_W'(1);
                r_time <= i_tok.secs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok.vld <= n_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok.clr   <= n_tok.clr;
            r_tok.known <= n_tok.known;
            r_tok.done  <= n_tok.done;
            r_tok.hit   <= n_tok.hit;
            r_tok.key   <= n_tok.key;
            r_tok.secs  <= n_tok.secs;
            r_tok.idx   <= n_tok.idx;
            r_tok.cnt   <= n_tok.cnt;
        end
    end

    assign o_tok = r_tok;

    // r_time holds the last-hit time; it is kept for readout, which lies
    // outside this block, so nothing here reads it back.

endmodule
